// ===== hw/rtl/slot_free_list_allocator_macros.svh =====
// Assertion macros shared by the slot allocator modules.
`ifndef SLOT_FREE_LIST_ALLOCATOR_MACROS_SVH
`define SLOT_FREE_LIST_ALLOCATOR_MACROS_SVH
`ifndef NO_ASSERTIONS
// Checks that the consequent holds in the same cycle as the antecedent.
`define SFLA_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Checks that the consequent holds in the cycle after the antecedent.
`define SFLA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define SFLA_ASSERT_SAME(label, ante, cons, msg)
`define SFLA_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

// ===== hw/rtl/sfla_pkg.sv =====
// Types and constants shared by the slot allocator modules.
package sfla_pkg;

    // Default number of slots the pool is built for.
    localparam int SLOTS_DEFAULT = 256;

    // Field widths.
    localparam int CMD_W    = 2;
    localparam int INDEX_W  = 8;
    localparam int COUNT_W  = 9;
    localparam int BYTES_W  = 17;
    localparam int OFFSET_W = 24;
    localparam int STATUS_W = 2;

    // Register reset values.
    localparam logic [COUNT_W-1:0] COUNT_RESET = 9'd256;
    localparam logic [BYTES_W-1:0] BYTES_RESET = 17'd4096;
    localparam logic [BYTES_W-1:0] BYTES_MAX   = 17'd65536;

    // Register indexes on the configuration port.
    typedef enum logic
    {
        REG_SLOT_COUNT = 1'b0,
        REG_SLOT_BYTES = 1'b1
    } reg_index_t;

    // Commands carried with each input word.
    typedef enum logic [CMD_W-1:0]
    {
        CMD_ACQUIRE = 2'd0,
        CMD_RELEASE = 2'd1,
        CMD_GET     = 2'd2,
        CMD_NONE    = 2'd3
    } command_t;

    // Result status codes.
    typedef enum logic [STATUS_W-1:0]
    {
        ST_OK        = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_FULL      = 2'd2,
        ST_BAD_INDEX = 2'd3
    } status_t;

    // Controller states.
    typedef enum logic
    {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed
    {
        logic capture;  // latch the input word and start the stack read
        logic execute;  // update the stack and load the result register
    } ctrl_cmd_t;

endpackage

// ===== hw/rtl/slot_free_list_allocator.sv =====
// Top level of the slot allocator: free-list stack of slot indices.
//
//  Channel   Direction  Handshake          Contents
//  s_*       in         tvalid/tready      command, slot index
//  m_*       out        tvalid/tready      status, granted index, byte offset, free count
//  p*        in/out     psel/penable       slot_count (0x0), slot_bytes (0x4)
//
// A word is captured in idle, which also reads the stack top from the
// registered-read stack memory, and worked on in exec, which updates the
// stack and loads the result register. No new word is taken during exec.
// Reset loads the stack with no clearing pass; a low-water mark stands in
// for the reload values. A stalled result holds the block in idle until taken.
module slot_free_list_allocator #(
    parameter int SLOTS = sfla_pkg::SLOTS_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // slot_index[7:0]
    input  logic [1:0]  s_tuser,   // command[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // granted_index[7:0], byte_offset[31:8],
                                   // free_left[40:32], zero fill[47:41]
    output logic [1:0]  m_tuser,   // status[1:0]
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    import sfla_pkg::*;

    ctrl_cmd_t            cmd;
    logic [STATUS_W-1:0]  status;
    logic [INDEX_W-1:0]   granted_index;
    logic [OFFSET_W-1:0]  byte_offset;
    logic [COUNT_W-1:0]   free_left;

    assign pready = 1'b1;

    // Sequencing and handshakes.
    sfla_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    // Stack, configuration and results.
    sfla_dpath #(
        .SLOTS (SLOTS)
    ) u_dpath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .in_command    (s_tuser),
        .in_slot_index (s_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr_sel     (paddr[2]),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .status        (status),
        .granted_index (granted_index),
        .byte_offset   (byte_offset),
        .free_left     (free_left)
    );

    // Pack the result word.
    assign m_tdata = {7'd0, free_left, byte_offset, granted_index};
    assign m_tuser = status;

endmodule

// ===== hw/rtl/sfla_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module sfla_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== hw/rtl/sfla_ctrl.sv =====
// Controller state machine of the slot allocator: handshakes and sequencing.
`include "slot_free_list_allocator_macros.svh"

module sfla_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output sfla_pkg::ctrl_cmd_t   cmd
);

    import sfla_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   accept;

    // A new word is taken only when idle and the result register is free
    // or being emptied in this cycle.
    assign s_tready = (state_reg == S_IDLE) && (!out_valid_reg || m_tready);
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;

    // State and result-valid registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Next state and datapath commands.
    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !m_tready;
        cmd.capture    = 1'b0;
        cmd.execute    = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC:
            begin
                cmd.execute    = 1'b1;
                out_valid_next = 1'b1;
                state_next     = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Every accepted word is worked on in the following cycle.
    `SFLA_ASSERT_NEXT(a_accept_to_exec, accept, state_reg == S_EXEC, "accept did not start work")
    // The exec state is always followed by idle.
    `SFLA_ASSERT_NEXT(a_exec_one_cycle, state_reg == S_EXEC, state_reg == S_IDLE, "work overran")
    // The result register is empty whenever a result is loaded into it.
    `SFLA_ASSERT_SAME(a_exec_out_free, state_reg == S_EXEC, !out_valid_reg, "result overwritten")
    // A result is offered right after work finishes.
    `SFLA_ASSERT_NEXT(a_exec_to_valid, state_reg == S_EXEC, out_valid_reg, "result not offered")

endmodule

// ===== hw/rtl/sfla_dpath.sv =====
// Datapath of the slot allocator: registers, free stack and result register.
`include "slot_free_list_allocator_macros.svh"

module sfla_dpath #(
    parameter int SLOTS = sfla_pkg::SLOTS_DEFAULT
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  sfla_pkg::ctrl_cmd_t            cmd,
    input  logic [sfla_pkg::CMD_W-1:0]     in_command,
    input  logic [sfla_pkg::INDEX_W-1:0]   in_slot_index,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic                           paddr_sel,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic [sfla_pkg::STATUS_W-1:0]  status,
    output logic [sfla_pkg::INDEX_W-1:0]   granted_index,
    output logic [sfla_pkg::OFFSET_W-1:0]  byte_offset,
    output logic [sfla_pkg::COUNT_W-1:0]   free_left
);

    import sfla_pkg::*;

    // The stack never holds more entries than an 8-bit index can name.
    localparam int STACK_DEPTH = (SLOTS < 256) ? SLOTS : 256;
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam logic [COUNT_W-1:0] CAP = COUNT_W'(STACK_DEPTH);

    logic [COUNT_W-1:0]  slot_count_reg;
    logic [BYTES_W-1:0]  slot_bytes_reg;
    logic [COUNT_W-1:0]  depth_reg;
    logic [COUNT_W-1:0]  depth_next;
    logic [COUNT_W-1:0]  low_reg;
    logic [COUNT_W-1:0]  low_next;
    logic [CMD_W-1:0]    command_reg;
    logic [INDEX_W-1:0]  index_reg;
    logic [STATUS_W-1:0] status_reg;
    logic [STATUS_W-1:0] status_next;
    logic [INDEX_W-1:0]  granted_reg;
    logic [INDEX_W-1:0]  granted_next;
    logic [OFFSET_W-1:0] offset_reg;
    logic [OFFSET_W-1:0] offset_next;
    logic [COUNT_W-1:0]  free_left_reg;

    logic                cfg_wr;
    logic                count_wr;
    logic                bytes_wr;
    logic [COUNT_W-1:0]  wr_count_eff;
    logic [COUNT_W-1:0]  count_eff;
    logic [BYTES_W-1:0]  bytes_eff;
    logic [OFFSET_W-1:0] product;
    logic                push_ok;
    logic [INDEX_W-1:0]  ram_rdata;
    logic [COUNT_W-1:0]  depth_minus_one;

    // Configuration writes; only bit 2 of the address selects the register.
    assign cfg_wr   = psel && penable && pwrite;
    assign count_wr = cfg_wr && (paddr_sel == REG_SLOT_COUNT);
    assign bytes_wr = cfg_wr && (paddr_sel == REG_SLOT_BYTES);

    // Register read-back.
    assign prdata = (paddr_sel == REG_SLOT_COUNT) ? {23'd0, slot_count_reg}
                                                  : {15'd0, slot_bytes_reg};

    // Clamp a raw slot count to the range the stack supports.
    function automatic logic [COUNT_W-1:0] clamp_count(input logic [COUNT_W-1:0] raw);
        logic [COUNT_W-1:0] c;
        c = raw;
        if (c == '0)
        begin
            c = 9'd1;
        end
        if (c > CAP)
        begin
            c = CAP;
        end
        return c;
    endfunction

    assign wr_count_eff = clamp_count(pwdata[COUNT_W-1:0]);
    assign count_eff    = clamp_count(slot_count_reg);

    // Clamp the slot size to 1..65536.
    always_comb
    begin
        bytes_eff = slot_bytes_reg;
        if (slot_bytes_reg == '0)
        begin
            bytes_eff = 17'd1;
        end
        else if (slot_bytes_reg > BYTES_MAX)
        begin
            bytes_eff = BYTES_MAX;
        end
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_count_reg <= COUNT_RESET;
            slot_bytes_reg <= BYTES_RESET;
        end
        else
        begin
            if (count_wr)
            begin
                slot_count_reg <= pwdata[COUNT_W-1:0];
            end
            if (bytes_wr)
            begin
                slot_bytes_reg <= pwdata[BYTES_W-1:0];
            end
        end
    end

    // Input word capture.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            command_reg <= in_command;
            index_reg   <= in_slot_index;
        end
    end

    // The free stack. Entries below the low-water mark still hold their
    // reload value (count - 1 - position) and are never read from memory.
    assign depth_minus_one = depth_reg - 9'd1;

    sfla_ram #(
        .WIDTH (INDEX_W),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .clk   (clk),
        .we    (push_ok),
        .waddr (depth_reg[ADDR_W-1:0]),
        .wdata (index_reg),
        .re    (cmd.capture),
        .raddr (depth_minus_one[ADDR_W-1:0]),
        .rdata (ram_rdata)
    );

    // Slot size times index for the offset lookup; the largest product fits
    // the offset field.
    assign product = OFFSET_W'(index_reg) * OFFSET_W'(bytes_eff);

    // Command execution.
    always_comb
    begin
        depth_next   = depth_reg;
        low_next     = low_reg;
        status_next  = ST_OK;
        granted_next = '0;
        offset_next  = '0;
        push_ok      = 1'b0;
        case (command_reg)
            CMD_ACQUIRE:
            begin
                if (depth_reg == '0)
                begin
                    status_next = ST_EMPTY;
                end
                else
                begin
                    depth_next = depth_minus_one;
                    if (depth_reg == low_reg)
                    begin
                        granted_next = INDEX_W'(count_eff - depth_reg);
                        low_next     = depth_minus_one;
                    end
                    else
                    begin
                        granted_next = ram_rdata;
                    end
                end
            end
            CMD_RELEASE:
            begin
                if ({1'b0, index_reg} >= count_eff)
                begin
                    status_next = ST_BAD_INDEX;
                end
                else if (depth_reg >= count_eff)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    push_ok    = cmd.execute;
                    depth_next = depth_reg + 9'd1;
                end
            end
            CMD_GET:
            begin
                if ({1'b0, index_reg} >= count_eff)
                begin
                    status_next = ST_BAD_INDEX;
                end
                else
                begin
                    offset_next = product;
                end
            end
            default:
            begin
                status_next = ST_OK;
            end
        endcase
    end

    // Stack pointer and low-water mark; a slot count write reloads both.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_reg <= CAP;
            low_reg   <= CAP;
        end
        else if (count_wr)
        begin
            depth_reg <= wr_count_eff;
            low_reg   <= wr_count_eff;
        end
        else if (cmd.execute)
        begin
            depth_reg <= depth_next;
            low_reg   <= low_next;
        end
    end

    // Result register.
    always_ff @(posedge clk)
    begin
        if (cmd.execute)
        begin
            status_reg    <= status_next;
            granted_reg   <= granted_next;
            offset_reg    <= offset_next;
            free_left_reg <= depth_next;
        end
    end

    assign status        = status_reg;
    assign granted_index = granted_reg;
    assign byte_offset   = offset_reg;
    assign free_left     = free_left_reg;

    // The low-water mark never rises above the stack pointer.
    `SFLA_ASSERT_SAME(a_low_below_depth, 1'b1, low_reg <= depth_reg, "low mark above depth")
    // The stack never holds more entries than slots in use.
    `SFLA_ASSERT_SAME(a_depth_in_count, 1'b1, depth_reg <= count_eff, "stack overfilled")
    // A push grows the stack by exactly one entry.
    `SFLA_ASSERT_NEXT(a_push_grows, push_ok && !count_wr, depth_reg == $past(depth_reg) + 9'd1, "push lost")

endmodule
